/* rtl/lsme_pkg.sv */
package lsme_pkg;

    localparam int MAX_SIDE_DEF     = 32;
    localparam int MAX_LAYERS_DEF   = 16;
    localparam int ORIENT_COUNT_DEF = 9;
    localparam int LAT_NBR          = 4;

    localparam int ORIENT_W     = 4;
    localparam int TYPE_W       = 2;
    localparam int SITE_W       = TYPE_W + ORIENT_W;
    localparam int TOTAL_W      = 15;
    localparam int STORE_AW_DEF = 2 * $clog2(MAX_SIDE_DEF) + $clog2(MAX_LAYERS_DEF);

    typedef logic [TYPE_W-1:0] t_site_type;

    localparam t_site_type SITE_SURFACE  = 2'd0;
    localparam t_site_type SITE_FLUID    = 2'd1;
    localparam t_site_type SITE_PARTICLE = 2'd2;

    localparam logic [1:0] CMD_MOVE  = 2'd0;
    localparam logic [1:0] CMD_QUERY = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    localparam logic [3:0] MOVE_ADSORB     = 4'd0;
    localparam logic [3:0] MOVE_DESORB     = 4'd1;
    localparam logic [3:0] MOVE_DIFF_FIRST = 4'd2;
    localparam logic [3:0] MOVE_DIFF_LAST  = 4'd5;
    localparam logic [3:0] MOVE_ROT_FIRST  = 4'd6;
    localparam logic [3:0] MOVE_ROT_LAST   = 4'd13;
    localparam logic [3:0] ROT_BIAS        = 4'd5;

    localparam logic [1:0] CFG_SIDE   = 2'd0;
    localparam logic [1:0] CFG_LAYERS = 2'd1;

    localparam logic [5:0]         SIDE_RST   = 6'd32;
    localparam logic [4:0]         LAYERS_RST = 5'd16;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX  = 15'h7fff;

    typedef struct packed {
        t_site_type          stype;
        logic [ORIENT_W-1:0] orient;
    } t_site;

    typedef struct packed {
        logic [1:0] cmd;
        logic [4:0] site_x;
        logic [4:0] site_y;
        logic [3:0] site_z;
        logic [3:0] move_kind;
    } t_lsme_in;

    typedef struct packed {
        logic        error;
        logic [1:0]  center_type;
        logic [1:0]  below_type;
        logic [1:0]  above_type;
        logic [2:0]  side_fluid;
        logic [2:0]  side_particle;
        logic [3:0]  orientation;
        logic [14:0] particle_count;
    } t_lsme_out;

endpackage

/* rtl/lattice_site_move_engine_top.sv */
// Lattice site move engine: holds a MAX_SIDE x MAX_SIDE x MAX_LAYERS lattice of sites (type and
// orientation) in one single-port store with a registered read, and serves one command word at a
// time through a small sequencer that drives that store's only port. A query issues seven site
// reads in ST_QUERY, one per cycle, captures each from the registered read data and then loads the
// output register in ST_DONE; the next word can be taken in the same cycle as the result shows.
// A move reads the site and its target in ST_RDA and ST_RDB and acts in ST_MOVE before its query;
// a diffusion adds a second write in ST_MOVE2 and a rotation loops in ST_ROT (the modulo is a
// repeated compare and subtract). A clear writes all 2**(2*clog2(MAX_SIDE)+clog2(MAX_LAYERS)) store
// entries, 16384 at the defaults, one per cycle, then gives a result. After reset the same clearing
// pass runs without a result and takes no command word; configuration writes are always taken.
module lattice_site_move_engine_top #(
    parameter int MAX_SIDE          = lsme_pkg::MAX_SIDE_DEF,
    parameter int MAX_LAYERS        = lsme_pkg::MAX_LAYERS_DEF,
    parameter int ORIENTATION_COUNT = lsme_pkg::ORIENT_COUNT_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  lsme_pkg::t_lsme_in  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output lsme_pkg::t_lsme_out o_out_data,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [5:0]          i_cfg_data
);

    import lsme_pkg::*;

    localparam int XW     = $clog2(MAX_SIDE);
    localparam int ZW     = $clog2(MAX_LAYERS);
    localparam int AW     = 2 * XW + ZW;
    localparam int SW     = $clog2(MAX_SIDE + 1);
    localparam int LW     = $clog2(MAX_LAYERS + 1);
    localparam int Q_LAST = 3 + LAT_NBR;
    localparam int QW     = $clog2(Q_LAST + 1);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_CLEAR = 4'd1;
    localparam logic [3:0] ST_RDA   = 4'd2;
    localparam logic [3:0] ST_RDB   = 4'd3;
    localparam logic [3:0] ST_MOVE  = 4'd4;
    localparam logic [3:0] ST_MOVE2 = 4'd5;
    localparam logic [3:0] ST_ROT   = 4'd6;
    localparam logic [3:0] ST_QUERY = 4'd7;
    localparam logic [3:0] ST_DONE  = 4'd8;

    localparam logic [1:0] DIR_LEFT  = 2'd0;
    localparam logic [1:0] DIR_FRONT = 2'd1;
    localparam logic [1:0] DIR_BACK  = 2'd2;

    // Query read slots: centre, below, above, then the lateral neighbours.
    localparam logic [QW-1:0] QS_CENTER = QW'(0);
    localparam logic [QW-1:0] QS_BELOW  = QW'(1);
    localparam logic [QW-1:0] QS_ABOVE  = QW'(2);
    localparam logic [QW-1:0] QS_LAT0   = QW'(3);

    // Lateral neighbour with periodic wrap at the side length in use.
    function automatic logic [AW-1:0] lat_addr(input logic [XW-1:0] x, input logic [XW-1:0] y,
                                               input logic [ZW-1:0] z, input logic [1:0] dir,
                                               input logic [SW-1:0] s);
        logic [XW-1:0] nx;
        logic [XW-1:0] ny;
        nx = x;
        ny = y;
        case (dir)
            DIR_LEFT:  nx = (x == '0) ? XW'(32'(s) - 1) : x - XW'(1);
            DIR_FRONT: ny = (y == '0) ? XW'(32'(s) - 1) : y - XW'(1);
            DIR_BACK:  ny = (32'(y) + 1 >= 32'(s)) ? '0 : y + XW'(1);
            default:   nx = (32'(x) + 1 >= 32'(s)) ? '0 : x + XW'(1);
        endcase
        return {z, ny, nx};
    endfunction

    logic [3:0]          r_state, n_state;
    t_lsme_in            r_item, n_item;
    logic                r_err, n_err;
    logic                r_zero, n_zero;
    t_site               r_a, n_a;
    logic [4:0]          r_sum, n_sum;
    logic [QW-1:0]       r_qi, n_qi;
    logic [AW-1:0]       r_clr, n_clr;
    logic                r_clr_reply, n_clr_reply;
    logic [TOTAL_W-1:0]  r_pt, n_pt;
    logic                r_out_valid, n_out_valid;
    t_lsme_out           r_out, n_out;
    t_site_type          r_c, n_c;
    logic [ORIENT_W-1:0] r_or, n_or;
    t_site_type          r_below, n_below;
    t_site_type          r_above, n_above;
    logic [2:0]          r_nf, n_nf;
    logic [2:0]          r_np, n_np;
    logic [5:0]          r_side;
    logic [4:0]          r_layers;

    logic [SW-1:0]     used_s;
    logic [LW-1:0]     used_l;
    logic [XW-1:0]     cx, cy;
    logic [ZW-1:0]     cz;
    logic [AW-1:0]     a_addr, b_addr, q_addr;
    logic              m_we;
    logic [AW-1:0]     m_addr;
    t_site             m_wdata;
    logic [SITE_W-1:0] m_rdata;
    t_site             rd;
    logic              in_acc;
    logic              in_err;
    logic [QW-1:0]     cap;

    // Saturate the registers to the sizes the store can hold.
    always_comb begin
        if (r_side == '0) begin
            used_s = SW'(1);
        end else if (32'(r_side) > MAX_SIDE) begin
            used_s = SW'(MAX_SIDE);
        end else begin
            used_s = SW'(r_side);
        end
        if (32'(r_layers) < 2) begin
            used_l = LW'(2);
        end else if (32'(r_layers) > MAX_LAYERS) begin
            used_l = LW'(MAX_LAYERS);
        end else begin
            used_l = LW'(r_layers);
        end
    end

    assign cx     = XW'(r_item.site_x);
    assign cy     = XW'(r_item.site_y);
    assign cz     = ZW'(r_item.site_z);
    assign a_addr = {cz, cy, cx};
    assign b_addr = lat_addr(cx, cy, cz, 2'(r_item.move_kind - MOVE_DIFF_FIRST), used_s);
    assign rd     = t_site'(m_rdata);
    assign in_acc = i_in_valid && (r_state == ST_IDLE);
    assign in_err = (32'(i_in_data.site_x) >= 32'(used_s))
                 || (32'(i_in_data.site_y) >= 32'(used_s))
                 || (32'(i_in_data.site_z) >= 32'(used_l));
    assign cap    = r_qi - QW'(1);

    always_comb begin
        case (r_qi)
            QS_CENTER: q_addr = a_addr;
            QS_BELOW:  q_addr = {cz - ZW'(1), cy, cx};
            QS_ABOVE:  q_addr = {cz + ZW'(1), cy, cx};
            default:   q_addr = lat_addr(cx, cy, cz, 2'(r_qi - QS_LAT0), used_s);
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_err       = r_err;
        n_zero      = r_zero;
        n_a         = r_a;
        n_sum       = r_sum;
        n_qi        = r_qi;
        n_clr       = r_clr;
        n_clr_reply = r_clr_reply;
        n_pt        = r_pt;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        n_c         = r_c;
        n_or        = r_or;
        n_below     = r_below;
        n_above     = r_above;
        n_nf        = r_nf;
        n_np        = r_np;
        m_we        = 1'b0;
        m_addr      = a_addr;
        m_wdata     = '0;

        // Drop the result word once the far side has taken it.
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_item = i_in_data;
                    n_zero = 1'b1;
                    n_err  = 1'b0;
                    n_qi   = '0;
                    case (i_in_data.cmd) inside
                        CMD_CLEAR: begin
                            n_state     = ST_CLEAR;
                            n_clr       = '0;
                            n_clr_reply = 1'b1;
                            n_pt        = '0;
                        end
                        CMD_MOVE, CMD_QUERY: begin
                            if (in_err) begin
                                n_err   = 1'b1;
                                n_state = ST_DONE;
                            end else begin
                                n_zero  = 1'b0;
                                n_state = (i_in_data.cmd == CMD_MOVE) ? ST_RDA : ST_QUERY;
                            end
                        end
                        default: n_state = ST_DONE;
                    endcase
                end
            end
            ST_CLEAR: begin
                m_we    = 1'b1;
                m_addr  = r_clr;
                m_wdata = '{stype: (r_clr[AW-1 -: ZW] == '0) ? SITE_SURFACE : SITE_FLUID,
                            orient: '0};
                n_clr   = r_clr + AW'(1);
                if (&r_clr) begin
                    n_state = r_clr_reply ? ST_DONE : ST_IDLE;
                end
            end
            ST_RDA: begin
                m_addr  = a_addr;
                n_state = ST_RDB;
            end
            ST_RDB: begin
                m_addr  = b_addr;
                n_a     = rd;
                n_state = ST_MOVE;
            end
            ST_MOVE: begin
                n_state = ST_QUERY;
                case (r_item.move_kind) inside
                    MOVE_ADSORB: begin
                        if (r_a.stype == SITE_FLUID) begin
                            m_we    = 1'b1;
                            m_wdata = '{stype: SITE_PARTICLE, orient: '0};
                            if (r_pt != TOTAL_MAX) n_pt = r_pt + TOTAL_W'(1);
                        end
                    end
                    MOVE_DESORB: begin
                        if (r_a.stype == SITE_PARTICLE) begin
                            m_we    = 1'b1;
                            m_wdata = '{stype: SITE_FLUID, orient: '0};
                            if (r_pt != '0) n_pt = r_pt - TOTAL_W'(1);
                        end
                    end
                    [MOVE_DIFF_FIRST:MOVE_DIFF_LAST]: begin
                        if (r_a.stype == SITE_PARTICLE && rd.stype == SITE_FLUID) begin
                            m_we    = 1'b1;
                            m_addr  = b_addr;
                            m_wdata = '{stype: SITE_PARTICLE, orient: r_a.orient};
                            n_state = ST_MOVE2;
                        end
                    end
                    [MOVE_ROT_FIRST:MOVE_ROT_LAST]: begin
                        if (r_a.stype == SITE_PARTICLE) begin
                            n_sum   = 5'(r_a.orient) + 5'(r_item.move_kind - ROT_BIAS);
                            n_state = ST_ROT;
                        end
                    end
                    default: ;
                endcase
            end
            ST_MOVE2: begin
                m_we    = 1'b1;
                m_wdata = '{stype: SITE_FLUID, orient: '0};
                n_state = ST_QUERY;
            end
            ST_ROT: begin
                if (32'(r_sum) >= ORIENTATION_COUNT) begin
                    n_sum = r_sum - 5'(ORIENTATION_COUNT);
                end else begin
                    m_we    = 1'b1;
                    m_wdata = '{stype: SITE_PARTICLE, orient: ORIENT_W'(r_sum)};
                    n_state = ST_QUERY;
                end
            end
            ST_QUERY: begin
                m_addr = q_addr;
                n_qi   = r_qi + QW'(1);
                if (r_qi == QS_CENTER) begin
                    n_nf = '0;
                    n_np = '0;
                end else begin
                    case (cap)
                        QS_CENTER: begin
                            n_c  = rd.stype;
                            n_or = rd.orient;
                        end
                        QS_BELOW: n_below = (cz == '0) ? SITE_SURFACE : rd.stype;
                        QS_ABOVE: begin
                            n_above = (32'(cz) + 1 >= 32'(used_l)) ? SITE_FLUID : rd.stype;
                        end
                        default: begin
                            if (rd.stype == SITE_FLUID) begin
                                n_nf = r_nf + 3'd1;
                            end else if (rd.stype == SITE_PARTICLE) begin
                                n_np = r_np + 3'd1;
                            end
                        end
                    endcase
                end
                if (r_qi == QW'(Q_LAST)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                // Hold until the output register is free, then load the word.
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid          = 1'b1;
                    n_out                = '0;
                    n_out.error          = r_err;
                    n_out.particle_count = r_pt;
                    if (!r_zero) begin
                        n_out.center_type   = r_c;
                        n_out.below_type    = r_below;
                        n_out.above_type    = r_above;
                        n_out.side_fluid    = r_nf;
                        n_out.side_particle = r_np;
                        n_out.orientation   = (r_c == SITE_PARTICLE) ? r_or : '0;
                    end
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_clr_reply <= 1'b0;
            r_pt        <= '0;
            r_out_valid <= 1'b0;
            r_side      <= SIDE_RST;
            r_layers    <= LAYERS_RST;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_clr_reply <= n_clr_reply;
            r_pt        <= n_pt;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_SIDE:   r_side   <= i_cfg_data;
                    CFG_LAYERS: r_layers <= i_cfg_data[4:0];
                    default: ;
                endcase
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        r_item  <= n_item;
        r_err   <= n_err;
        r_zero  <= n_zero;
        r_a     <= n_a;
        r_sum   <= n_sum;
        r_qi    <= n_qi;
        r_out   <= n_out;
        r_c     <= n_c;
        r_or    <= n_or;
        r_below <= n_below;
        r_above <= n_above;
        r_nf    <= n_nf;
        r_np    <= n_np;
    end

    lsme_store #(
        .AW(AW),
        .DW(SITE_W)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (m_we),
        .i_addr (m_addr),
        .i_wdata(m_wdata),
        .o_rdata(m_rdata)
    );

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

endmodule

/* rtl/lsme_store.sv */
module lsme_store #(
    parameter int AW = lsme_pkg::STORE_AW_DEF,
    parameter int DW = lsme_pkg::SITE_W
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_addr,
    input  logic [DW-1:0] i_wdata,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [2**AW];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule
